// ===== design/slz_pkg.sv =====
// ----------------------------------------------------------------------------
// slz_pkg
// Shared types and constants of the stochastic Lorenz step core.
// ----------------------------------------------------------------------------
package slz_pkg;

  // Fixed point format of positions
  localparam int FRAC_BITS = 20;
  localparam int POS_W     = 32;

  // Noise operands: gain unsigned Q4.12, sample signed Q3.12
  localparam int GAIN_W      = 16;
  localparam int SAMP_W      = 16;
  localparam int NOISE_SHIFT = 24;

  // Shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int PQ_W   = PROD_W - FRAC_BITS;

  // Shared divider: signed numerator, quotient built one 16-bit digit at a time
  localparam int DIG_W      = 16;
  localparam int NUM_W      = ((67 - FRAC_BITS + DIG_W - 1) / DIG_W) * DIG_W;
  localparam int NUM_DIGITS = NUM_W / DIG_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int DVS_W      = 9;
  localparam int REM_W      = DVS_W + 1;

  // Partial dividend of one digit step and its reciprocal scaling;
  // divisors are at least 10, so the reciprocal fits RCP_SHIFT - 3 bits
  localparam int T_W       = DVS_W + DIG_W;
  localparam int RCP_SHIFT = T_W;
  localparam int RCP_W     = RCP_SHIFT - 3;

  // Position accumulator before saturation
  localparam int ACC_W = NUM_W + 1;

  localparam logic [DVS_W-1:0] DVS_DX    = DVS_W'(10);
  localparam logic [DVS_W-1:0] DVS_DY    = DVS_W'(100);
  localparam logic [DVS_W-1:0] DVS_DZ    = DVS_W'(300);
  localparam logic [DVS_W-1:0] DVS_NOISE = DVS_W'(10);

  // Truncated reciprocals, floor(2^RCP_SHIFT / divisor)
  localparam logic [RCP_W-1:0] RCP_DX = RCP_W'((64'd1 << RCP_SHIFT) / 64'(DVS_DX));
  localparam logic [RCP_W-1:0] RCP_DY = RCP_W'((64'd1 << RCP_SHIFT) / 64'(DVS_DY));
  localparam logic [RCP_W-1:0] RCP_DZ = RCP_W'((64'd1 << RCP_SHIFT) / 64'(DVS_DZ));

  localparam logic [PROD_W-1:0] RND_HALF    = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND_HALF_M1 = RND_HALF - PROD_W'(1);
  localparam logic [PROD_W-1:0] NOISE_BIAS  = (PROD_W'(1) << NOISE_SHIFT) - PROD_W'(1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MULRES,
    ST_DIV,
    ST_DIVWAIT,
    ST_FIN
  } state_t;

  // Micro-operations of one integration step, in issue order
  typedef enum logic [3:0] {
    OP_SD,
    OP_XZ,
    OP_XY,
    OP_DX,
    OP_DY,
    OP_DZ,
    OP_NX,
    OP_NY,
    OP_NZ
  } op_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DVS_W-1:0]        dvs;
  } div_req_t;

endpackage

// ===== design/slz_mul.sv =====
// ----------------------------------------------------------------------------
// slz_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module slz_mul
  import slz_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// ===== design/slz_div.sv =====
// ----------------------------------------------------------------------------
// slz_div
// Iterative divider by a small constant divisor, rounding to nearest with
// ties away from zero. Each 16-bit quotient digit takes two steps: a
// reciprocal estimate, then one compare and subtract.
// ----------------------------------------------------------------------------
module slz_div
  import slz_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_req_t                req,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  logic             busy_r, busy_nxt;
  logic             phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] work_r, work_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIG_W-1:0] qest_r, qest_nxt;
  logic             neg_r, neg_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [RCP_W-1:0] rcp_r, rcp_nxt;

  always_comb begin
    logic [T_W-1:0]       t;
    logic [T_W+RCP_W-1:0] est;
    logic [T_W-1:0]       diff;
    logic [REM_W-1:0]     r;
    logic [DIG_W-1:0]     q;
    logic [NUM_W-1:0]     mag;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    qest_nxt  = qest_r;
    neg_nxt   = neg_r;
    dvs_nxt   = dvs_r;
    rcp_nxt   = rcp_r;
    // partial dividend: remainder so far followed by the next numerator digit
    t    = {rem_r, work_r[NUM_W-1 -: DIG_W]};
    est  = (T_W+RCP_W)'(t) * (T_W+RCP_W)'(rcp_r);
    // the estimate is the digit or one below it
    diff = t - T_W'(qest_r) * T_W'(dvs_r);
    r    = diff[REM_W-1:0];
    q    = qest_r;
    if (r >= REM_W'(dvs_r)) begin
      r = r - REM_W'(dvs_r);
      q = qest_r + DIG_W'(1);
    end
    mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    if (req.start) begin
      // add half the divisor so that the floor below rounds
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = '0;
      work_nxt  = mag + NUM_W'(req.dvs >> 1);
      rem_nxt   = '0;
      neg_nxt   = req.num[NUM_W-1];
      dvs_nxt   = req.dvs;
      case (req.dvs)
        DVS_DY:  rcp_nxt = RCP_DY;
        DVS_DZ:  rcp_nxt = RCP_DZ;
        default: rcp_nxt = RCP_DX;
      endcase
    end else if (busy_r) begin
      if (!phase_r) begin
        qest_nxt  = est[RCP_SHIFT +: DIG_W];
        phase_nxt = 1'b1;
      end else begin
        // shift the numerator digit out and the quotient digit in
        work_nxt  = {work_r[NUM_W-DIG_W-1:0], q};
        rem_nxt   = r[DVS_W-1:0];
        phase_nxt = 1'b0;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_DIGITS - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    qest_r <= qest_nxt;
    neg_r  <= neg_nxt;
    dvs_r  <= dvs_nxt;
    rcp_r  <= rcp_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(work_r) : $signed(work_r);

endmodule

// ===== design/stochastic_lorenz_step_core.sv =====
// ----------------------------------------------------------------------------
// stochastic_lorenz_step_core
// Euler-Maruyama step of the Lorenz system with multiplicative noise.
//
// Input channel (in_valid / in_stall): a word carries in_kind and
// in_normal_sample. kind 1 loads origin plus offset, kind 0 takes one
// integration step with the Q3.12 sample as noise.
// Output channel (out_valid / out_stall): one word per input word, the new
// position out_x, out_y, out_z in signed Q11.20, saturated to 32 bits.
// Config channel (cfg_valid / cfg_ready): write cfg_data to register
// cfg_index (origin x,y,z, offset x,y,z, noise gain); always ready.
// A restart goes from idle straight to the final state, which registers
// the result. A step makes six passes through the shared multiplier and
// six through the shared divider before the final state; the divider
// builds each 16-bit quotient digit from a reciprocal estimate and one
// compare and subtract. The input stalls until the result is registered
// and the block is back in idle.
// Reset clears position and registers to zero and empties the output.
// A stalled output holds its word; the finished next position waits until
// the receiver takes the previous one.
// ----------------------------------------------------------------------------
module stochastic_lorenz_step_core
  import slz_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [SAMP_W-1:0] in_normal_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_x,
  output logic signed [POS_W-1:0]  out_y,
  output logic signed [POS_W-1:0]  out_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [POS_W-1:0]         cfg_data
);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (&v[ACC_W-1:POS_W-1] || ~|v[ACC_W-1:POS_W-1]) begin
      r = v[POS_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic signed [POS_W-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [POS_W-1:0] off_x_r, off_y_r, off_z_r;
  logic [GAIN_W-1:0]       gain_r;

  logic signed [POS_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic signed [POS_W-1:0]  pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic signed [SAMP_W-1:0] samp_r, samp_nxt;
  logic signed [POS_W-1:0]  sd_r, sd_nxt;
  logic signed [PQ_W-1:0]   xz_r, xz_nxt, xy_r, xy_nxt;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r, acc_z_r;
  logic signed [ACC_W-1:0]  acc_x_nxt, acc_y_nxt, acc_z_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd, prod_q, noise_adj, noise_sh;
  logic signed [NUM_W-1:0]  xe, ye, ze, xze, xye;
  logic signed [NUM_W-1:0]  num_dx, num_dy, num_dz, num_noise;

  div_req_t                 div_req;
  logic                     div_done;
  logic signed [NUM_W-1:0]  div_quo;

  slz_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  slz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_x     = pos_x_r;
  assign out_y     = pos_y_r;
  assign out_z     = pos_z_r;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_SD: begin
        mul_a = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_r});
        mul_b = MUL_W'(samp_r);
      end
      OP_XZ: begin
        mul_a = MUL_W'(pos_x_r);
        mul_b = MUL_W'(pos_z_r);
      end
      OP_XY: begin
        mul_a = MUL_W'(pos_x_r);
        mul_b = MUL_W'(pos_y_r);
      end
      OP_NX: begin
        mul_a = MUL_W'(pos_x_r);
        mul_b = MUL_W'(sd_r);
      end
      OP_NY: begin
        mul_a = MUL_W'(pos_y_r);
        mul_b = MUL_W'(sd_r);
      end
      OP_NZ: begin
        mul_a = MUL_W'(pos_z_r);
        mul_b = MUL_W'(sd_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product rounding and divider numerators
  assign prod_rnd  = prod + $signed(prod[PROD_W-1] ? RND_HALF_M1 : RND_HALF);
  assign prod_q    = prod_rnd >>> FRAC_BITS;
  assign noise_adj = prod + $signed(prod[PROD_W-1] ? NOISE_BIAS : '0);
  assign noise_sh  = noise_adj >>> NOISE_SHIFT;
  assign num_noise = noise_sh[NUM_W-1:0];

  assign xe  = NUM_W'(pos_x_r);
  assign ye  = NUM_W'(pos_y_r);
  assign ze  = NUM_W'(pos_z_r);
  assign xze = NUM_W'(xz_r);
  assign xye = NUM_W'(xy_r);

  assign num_dx = ye - xe;
  assign num_dy = (xe <<< 5) - (xe <<< 2) - xze - ye;
  assign num_dz = (xye <<< 1) + xye - (ze <<< 3);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && out_stall;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    samp_nxt      = samp_r;
    sd_nxt        = sd_r;
    xz_nxt        = xz_r;
    xy_nxt        = xy_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    acc_z_nxt     = acc_z_r;
    div_req.start = 1'b0;
    div_req.num   = num_dx;
    div_req.dvs   = DVS_DX;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          samp_nxt = in_normal_sample;
          if (in_kind) begin
            acc_x_nxt = ACC_W'(org_x_r) + ACC_W'(off_x_r);
            acc_y_nxt = ACC_W'(org_y_r) + ACC_W'(off_y_r);
            acc_z_nxt = ACC_W'(org_z_r) + ACC_W'(off_z_r);
            state_nxt = ST_FIN;
          end else begin
            acc_x_nxt = ACC_W'(pos_x_r);
            acc_y_nxt = ACC_W'(pos_y_r);
            acc_z_nxt = ACC_W'(pos_z_r);
            op_nxt    = OP_SD;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_MULRES;
      end
      ST_MULRES: begin
        case (op_r)
          OP_SD: sd_nxt = prod[POS_W-1:0];
          OP_XZ: xz_nxt = prod_q[PQ_W-1:0];
          OP_XY: xy_nxt = prod_q[PQ_W-1:0];
          default: begin
            div_req.start = 1'b1;
            div_req.num   = num_noise;
            div_req.dvs   = DVS_NOISE;
          end
        endcase
        case (op_r)
          OP_SD, OP_XZ: begin
            op_nxt    = op_t'(op_r + 4'd1);
            state_nxt = ST_MUL;
          end
          OP_XY: begin
            op_nxt    = OP_DX;
            state_nxt = ST_DIV;
          end
          default: state_nxt = ST_DIVWAIT;
        endcase
      end
      ST_DIV: begin
        div_req.start = 1'b1;
        case (op_r)
          OP_DY: begin
            div_req.num = num_dy;
            div_req.dvs = DVS_DY;
          end
          OP_DZ: begin
            div_req.num = num_dz;
            div_req.dvs = DVS_DZ;
          end
          default: begin
            div_req.num = num_dx;
            div_req.dvs = DVS_DX;
          end
        endcase
        state_nxt = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          case (op_r)
            OP_DX, OP_NX: acc_x_nxt = acc_x_r + ACC_W'(div_quo);
            OP_DY, OP_NY: acc_y_nxt = acc_y_r + ACC_W'(div_quo);
            default:      acc_z_nxt = acc_z_r + ACC_W'(div_quo);
          endcase
          op_nxt = op_t'(op_r + 4'd1);
          case (op_r)
            OP_NZ:        state_nxt = ST_FIN;
            OP_DX, OP_DY: state_nxt = ST_DIV;
            default:      state_nxt = ST_MUL;
          endcase
        end
      end
      ST_FIN: begin
        // hold the new position until the previous word is taken
        if (!out_valid_r || !out_stall) begin
          pos_x_nxt     = sat_pos(acc_x_r);
          pos_y_nxt     = sat_pos(acc_y_r);
          pos_z_nxt     = sat_pos(acc_z_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SD;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r  <= samp_nxt;
    sd_r    <= sd_nxt;
    xz_r    <= xz_nxt;
    xy_r    <= xy_nxt;
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
    acc_z_r <= acc_z_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      gain_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org_x_r <= cfg_data;
        REG_ORIGIN_Y: org_y_r <= cfg_data;
        REG_ORIGIN_Z: org_z_r <= cfg_data;
        REG_OFFSET_X: off_x_r <= cfg_data;
        REG_OFFSET_Y: off_y_r <= cfg_data;
        REG_OFFSET_Z: off_z_r <= cfg_data;
        REG_GAIN:     gain_r  <= cfg_data[GAIN_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

// ===== test/tb_stochastic_lorenz_step_core.sv =====
// ----------------------------------------------------------------------------
// tb_stochastic_lorenz_step_core
// Self-checking bench for the stochastic Lorenz step core. A bit-exact
// predictor tracks position and register state. Each position word on the
// output is checked against it. Stimulus is a directed part covering reset,
// restarts, sample extremes and saturation, then random phases under several
// register settings. Both channels see random gaps and stalls, including one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_stochastic_lorenz_step_core;
  import slz_pkg::*;

  localparam logic KIND_STEP    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [SAMP_W-1:0] sample;
  } lorenz_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } position_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_kind = KIND_STEP;
  logic signed [SAMP_W-1:0] in_normal_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic signed [POS_W-1:0]  out_z;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_ORIGIN_X;
  logic [POS_W-1:0]         cfg_data = '0;

  stochastic_lorenz_step_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_normal_sample (in_normal_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: registers and current position
  logic signed [POS_W-1:0]  origin_r [3] = '{default: '0};
  logic signed [POS_W-1:0]  offset_r [3] = '{default: '0};
  logic [GAIN_W-1:0]        gain_r = '0;
  logic signed [POS_W-1:0]  cur_x = '0;
  logic signed [POS_W-1:0]  cur_y = '0;
  logic signed [POS_W-1:0]  cur_z = '0;

  lorenz_word_t pending_words [$];
  position_t    expected_pos [$];

  int fail_count = 0;
  int checked_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit word_taken = 1'b0;
  int hold_left = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  // Round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_div(a * b, longint'(1) << FRAC_BITS);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[POS_W-1:0];
  endfunction

  function automatic position_t advance_lorenz(lorenz_word_t w);
    longint x, y, z, sd, nd, dx, dy, dz;
    position_t p;
    x = cur_x;
    y = cur_y;
    z = cur_z;
    if (w.kind == KIND_RESTART) begin
      cur_x = clamp32(longint'(origin_r[0]) + longint'(offset_r[0]));
      cur_y = clamp32(longint'(origin_r[1]) + longint'(offset_r[1]));
      cur_z = clamp32(longint'(origin_r[2]) + longint'(offset_r[2]));
    end else begin
      // gain Q4.12 times sample Q3.12 gives a Q.24 noise factor
      sd = longint'(gain_r) * longint'($signed(w.sample));
      nd = longint'(10) << NOISE_SHIFT;
      dx = round_div(y - x, 10);
      dy = round_div(28 * x - qmul(x, z) - y, 100);
      dz = round_div(3 * qmul(x, y) - 8 * z, 300);
      cur_x = clamp32(x + dx + round_div(x * sd, nd));
      cur_y = clamp32(y + dy + round_div(y * sd, nd));
      cur_z = clamp32(z + dz + round_div(z * sd, nd));
    end
    p.x = cur_x;
    p.y = cur_y;
    p.z = cur_z;
    return p;
  endfunction

  function automatic int next_gap();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 0;
    if (sel < 8) return $urandom_range(1, 4);
    if (sel < 9) return $urandom_range(5, 30);
    return $urandom_range(60, 120);
  endfunction

  function automatic lorenz_word_t random_word();
    lorenz_word_t w;
    int acc;
    w.kind = ($urandom_range(0, 99) < 8) ? KIND_RESTART : KIND_STEP;
    if ($urandom_range(0, 9) < 7) begin
      // rough bell shape, about +-4.0 in Q3.12
      acc = 0;
      repeat (4) acc += $urandom_range(0, 8192);
      w.sample = SAMP_W'(acc - 16384);
    end else begin
      w.sample = SAMP_W'($urandom);
    end
    return w;
  endfunction

  function automatic logic signed [POS_W-1:0] moderate_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic queue_word(logic kind, logic signed [SAMP_W-1:0] sample);
    lorenz_word_t w;
    w.kind = kind;
    w.sample = sample;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_ORIGIN_X: origin_r[0] = data;
      REG_ORIGIN_Y: origin_r[1] = data;
      REG_ORIGIN_Z: origin_r[2] = data;
      REG_OFFSET_X: offset_r[0] = data;
      REG_OFFSET_Y: offset_r[1] = data;
      REG_OFFSET_Z: offset_r[2] = data;
      REG_GAIN:     gain_r = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [POS_W-1:0] ox, logic [POS_W-1:0] oy, logic [POS_W-1:0] oz,
                           logic [POS_W-1:0] fx, logic [POS_W-1:0] fy, logic [POS_W-1:0] fz,
                           logic [GAIN_W-1:0] g);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_OFFSET_X, fx);
    write_reg(REG_OFFSET_Y, fy);
    write_reg(REG_OFFSET_Z, fz);
    // upper data bits are don't-care for the gain register
    write_reg(REG_GAIN, {(POS_W - GAIN_W)'($urandom), g});
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_pos.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sender: bursts of words with random gaps; hold a word until taken
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        in_valid         <= 1'b1;
        in_kind          <= pending_words[0].kind;
        in_normal_sample <= pending_words[0].sample;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = next_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted input word: advance the predicted position
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      expected_pos.push_back(advance_lorenz(pending_words.pop_front()));
      word_taken = 1'b1;
    end
  end

  // Receiver: stall pattern changes mode now and then; one long hold-off
  always @(negedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      hold_left = 800;
      hold_off_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Output check against the oldest predicted position
  always @(posedge clk) begin
    position_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_pos.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected position word: x=%h y=%h z=%h", out_x, out_y, out_z);
      end else begin
        want = expected_pos.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z) begin
          fail_count++;
          if (fail_count <= 10)
            $display("word %0d mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                     checked_count, want.x, want.y, want.z, out_x, out_y, out_z);
        end
      end
      checked_count++;
    end
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int ph;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero position is a fixed point under reset registers
    queue_word(KIND_STEP, 16'sh7fff);
    queue_word(KIND_RESTART, 16'sh0000);
    wait_idle();

    write_all(32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000,
              32'sh0008_0000, -32'sh0004_0000, 32'sh0140_0000, 16'h1000);
    queue_word(KIND_RESTART, 16'sh0000);
    queue_word(KIND_STEP, 16'sh7fff);
    queue_word(KIND_STEP, -16'sh8000);
    queue_word(KIND_STEP, 16'sh0000);
    queue_word(KIND_STEP, 16'sh0001);
    queue_word(KIND_STEP, -16'sh0001);
    queue_word(KIND_STEP, 16'sh5555);
    queue_word(KIND_STEP, -16'sh5556);
    queue_word(KIND_RESTART, -16'sh0001);
    queue_word(KIND_STEP, 16'sh1000);
    queue_word(KIND_STEP, -16'sh1000);
    wait_idle();

    // saturated restart sums and steps from the range limits at full gain
    write_all(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 16'hffff);
    queue_word(KIND_RESTART, 16'sh0000);
    queue_word(KIND_STEP, 16'sh7fff);
    queue_word(KIND_STEP, -16'sh8000);
    queue_word(KIND_STEP, 16'sh0000);
    queue_word(KIND_RESTART, 16'sh7fff);
    queue_word(KIND_STEP, -16'sh8000);
    queue_word(KIND_STEP, 16'sh0001);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(moderate_coord(20 << FRAC_BITS), moderate_coord(20 << FRAC_BITS),
                     moderate_coord(25 << FRAC_BITS), moderate_coord(1 << 16),
                     moderate_coord(1 << 16), moderate_coord(1 << 16), '0);
        1: write_all(moderate_coord(20 << FRAC_BITS), moderate_coord(20 << FRAC_BITS),
                     moderate_coord(25 << FRAC_BITS), moderate_coord(1 << 16),
                     moderate_coord(1 << 16), moderate_coord(1 << 16),
                     GAIN_W'($urandom_range(1, 16'h1000)));
        2: write_all(moderate_coord(20 << FRAC_BITS), moderate_coord(20 << FRAC_BITS),
                     moderate_coord(25 << FRAC_BITS), moderate_coord(1 << 20),
                     moderate_coord(1 << 20), moderate_coord(1 << 20), 16'hffff);
        3: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     GAIN_W'($urandom));
        4: write_all(moderate_coord(20 << FRAC_BITS), moderate_coord(20 << FRAC_BITS),
                     moderate_coord(25 << FRAC_BITS), '0, '0, '0,
                     GAIN_W'($urandom_range(0, 16'h3000)));
        default: write_all(moderate_coord(20 << FRAC_BITS), moderate_coord(20 << FRAC_BITS),
                           moderate_coord(25 << FRAC_BITS), $urandom, $urandom, $urandom,
                           16'h0001);
      endcase
      // start each phase from the configured point
      queue_word(KIND_RESTART, SAMP_W'($urandom));
      repeat (179) pending_words.push_back(random_word());
      if (ph == 1) hold_off_req = 1'b1;
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (expected_pos.size() != 0) fail_count += expected_pos.size();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
